[design/sbf_pkg.sv]
// Package with the fixed register widths and configuration codes of the spring force block.
`default_nettype none
package sbf_pkg;

  localparam int unsigned KW       = 32;  // stiffness width
  localparam int unsigned RW       = 31;  // rest length width
  localparam int unsigned CFG_IDXW = 2;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [CFG_IDXW-1:0] CFG_SPRING_CONSTANT = 2'd0;
  localparam logic [CFG_IDXW-1:0] CFG_REST_LENGTH     = 2'd1;
  localparam logic [CFG_IDXW-1:0] CFG_MODE            = 2'd2;

  localparam logic [KW-1:0] K_RESET    = 32'h0001_0000;
  localparam logic [RW-1:0] REST_RESET = 31'h0001_0000;

endpackage
`default_nettype wire

[design/spring_bungee_force.sv]
// Top level of the pipelined Hooke spring and bungee force unit.
//
// spring_bungee_force takes one item per cycle on the slave stream: a particle
// position and the position of the other end, all signed fixed point with
// FRAC_BITS fraction bits. It returns one item per input item, in order, on the
// master stream: the force -k*(L - rest)*d/L on the particle, each component
// truncated toward zero and clamped to COORD_WIDTH bits, with a flag in tuser
// when any component was clamped. In bungee mode the force is zero while the
// cord is slack, and a zero separation always gives a zero force. The whole
// pipeline advances together, so the sustained rate is one item per clock
// while the output is taken; each item passes through the digit-by-digit
// square root and the restoring divider plus nine more stages. When the
// output item is not taken, the whole pipeline holds and the slave side
// deasserts tready. Configuration is written through its own channel, which
// is always ready; write it only while idle.
`default_nettype none
module spring_bungee_force #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // pos_x, pos_y, pos_z, end_x, end_y, end_z from the lowest bit up
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // force_x, force_y, force_z from the lowest bit up
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // saturated
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [sbf_pkg::CFG_IDXW-1:0]        cfg_index_i,
  input  wire logic [sbf_pkg::CFG_DW-1:0]          cfg_data_i
);
  import sbf_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned OW   = ((3*CW+7)/8)*8;
  localparam int unsigned DW   = CW + 1;              // difference and its magnitude
  localparam int unsigned LW   = DW + 1;              // length, root digits
  localparam int unsigned SQW  = 2 * LW;              // sum of squares
  localparam int unsigned RMW  = LW + 3;              // root remainder
  localparam int unsigned AW   = (LW > RW) ? LW : RW; // |delta|
  localparam int unsigned EW   = AW + 1;              // signed delta
  localparam int unsigned MW   = KW + AW;             // k * |delta|
  localparam int unsigned HW   = (MW + 1) / 2;        // low partial product split
  localparam int unsigned PW   = MW + DW;             // full numerator
  localparam int unsigned QW   = CW + 1;              // quotient digits kept
  localparam int unsigned DVW  = LW + FRAC_BITS;      // divisor L * 2^FRAC_BITS
  localparam int unsigned CMPW = PW - QW;
  localparam int unsigned NST  = 3 + LW + 5 + QW + 1;

  typedef struct packed {
    logic [2:0][DW-1:0] mag;
    logic [2:0]         neg;
  } vec_t;

  typedef struct packed {
    logic [LW-1:0] len;
    logic          dneg;
    logic          kill;
    vec_t          ax;
  } carry_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [QW-1:0]  low;
    logic [QW-1:0]  quo;
    logic           big;
  } divc_t;

  // Configuration registers.
  logic [KW-1:0] k_q;
  logic [RW-1:0] rest_q;
  logic          mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= K_RESET;
      rest_q <= REST_RESET;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPRING_CONSTANT: k_q    <= cfg_data_i[KW-1:0];
        CFG_REST_LENGTH:     rest_q <= cfg_data_i[RW-1:0];
        CFG_MODE:            mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; valid bits ride along with the stages.
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv           = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Difference and its magnitude per axis.
  vec_t dif_d, dif_q;
  always_comb begin
    logic [DW-1:0] p, e, d;
    for (int c = 0; c < 3; c++) begin
      p = DW'($signed(s_axis_tdata[c*CW +: CW]));
      e = DW'($signed(s_axis_tdata[(c+3)*CW +: CW]));
      d = p - e;
      dif_d.neg[c] = d[DW-1];
      dif_d.mag[c] = d[DW-1] ? (~d + 1'b1) : d;
    end
  end

  // Squares, then their sum.
  logic [2:0][2*DW-1:0] sq_q;
  vec_t                 sqv_q, sumv_q;
  logic [SQW-1:0]       sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dif_q  <= dif_d;
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= dif_q.mag[c] * dif_q.mag[c];
      end
      sqv_q  <= dif_q;
      sum_q  <= SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
      sumv_q <= sqv_q;
    end
  end

  // Square root, one result bit per stage.
  logic [LW-1:0]  rt_q [LW];
  logic [RMW-1:0] rm_q [LW];
  logic [SQW-1:0] rd_q [LW];
  vec_t           rv_q [LW];

  for (genvar i = 0; i < LW; i++) begin : gen_sqrt
    logic [LW-1:0]  tin;
    logic [RMW-1:0] rin, r2, trial;
    logic [SQW-1:0] din;
    vec_t           vin;
    logic           ge;

    if (i == 0) begin : gen_first
      assign tin = '0;
      assign rin = '0;
      assign din = sum_q;
      assign vin = sumv_q;
    end else begin : gen_next
      assign tin = rt_q[i-1];
      assign rin = rm_q[i-1];
      assign din = rd_q[i-1];
      assign vin = rv_q[i-1];
    end

    assign r2    = {rin[RMW-3:0], din[SQW-1 -: 2]};
    assign trial = {{(RMW-LW-2){1'b0}}, tin, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rm_q[i] <= ge ? (r2 - trial) : r2;
        rt_q[i] <= {tin[LW-2:0], ge};
        rd_q[i] <= din << 2;
        rv_q[i] <= vin;
      end
    end
  end

  // Stretch relative to rest length and the cases that give no force.
  carry_t        dl_d, dl_q, m_c_q, pp_c_q, pr_c_q, ov_c_q;
  logic [AW-1:0] adl_d, adl_q;

  always_comb begin
    logic [EW-1:0] delta;
    delta          = EW'(rt_q[LW-1]) - EW'(rest_q);
    dl_d.len       = rt_q[LW-1];
    dl_d.dneg      = delta[EW-1];
    dl_d.ax        = rv_q[LW-1];
    dl_d.kill      = (rt_q[LW-1] == '0) || (delta == '0) ||
                     (mode_q && (delta[EW-1] || (delta == '0)));
    adl_d          = delta[EW-1] ? AW'(~delta + 1'b1) : AW'(delta);
  end

  logic [MW-1:0]                m_q;
  logic [2:0][HW+DW-1:0]        plo_q;
  logic [2:0][MW-HW+DW-1:0]     phi_q;
  logic [2:0][PW-1:0]           prod_q;
  divc_t [2:0]                  ov_d, ov_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ov_d[c].big = (prod_q[c][PW-1:QW] >=
                     CMPW'({pr_c_q.len, {FRAC_BITS{1'b0}}}));
      ov_d[c].rem = prod_q[c][QW+DVW-1:QW];
      ov_d[c].low = prod_q[c][QW-1:0];
      ov_d[c].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q   <= dl_d;
      adl_q  <= adl_d;
      m_q    <= k_q * adl_q;
      m_c_q  <= dl_q;
      for (int c = 0; c < 3; c++) begin
        plo_q[c]  <= m_q[HW-1:0] * m_c_q.ax.mag[c];
        phi_q[c]  <= m_q[MW-1:HW] * m_c_q.ax.mag[c];
        prod_q[c] <= PW'(plo_q[c]) + (PW'(phi_q[c]) << HW);
      end
      pp_c_q <= m_c_q;
      pr_c_q <= pp_c_q;
      ov_q   <= ov_d;
      ov_c_q <= pr_c_q;
    end
  end

  // Restoring division by L * 2^FRAC_BITS, one quotient bit per stage.
  divc_t [2:0] dv_q [QW];
  carry_t      dc_q [QW];

  for (genvar j = 0; j < QW; j++) begin : gen_div
    divc_t [2:0] din, dnx;
    carry_t      cin;

    if (j == 0) begin : gen_first
      assign din = ov_q;
      assign cin = ov_c_q;
    end else begin : gen_next
      assign din = dv_q[j-1];
      assign cin = dc_q[j-1];
    end

    always_comb begin
      logic [DVW:0] r2, dv;
      dv = {1'b0, cin.len, {FRAC_BITS{1'b0}}};
      for (int c = 0; c < 3; c++) begin
        r2          = {din[c].rem, din[c].low[QW-1]};
        dnx[c].big  = din[c].big;
        dnx[c].low  = din[c].low << 1;
        dnx[c].rem  = (r2 >= dv) ? DVW'(r2 - dv) : DVW'(r2);
        dnx[c].quo  = {din[c].quo[QW-2:0], (r2 >= dv)};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j] <= dnx;
        dc_q[j] <= cin;
      end
    end
  end

  // Sign, clamp and output register.
  localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);

  logic [2:0][CW-1:0] f_d;
  logic               sat_d;
  logic [OW-1:0]      tdata_q;
  logic               tuser_q;

  always_comb begin
    carry_t cf;
    divc_t  r;
    logic   neg;
    cf    = dc_q[QW-1];
    sat_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      r   = dv_q[QW-1][c];
      neg = (cf.dneg == cf.ax.neg[c]);
      if (cf.kill || (cf.ax.mag[c] == '0)) begin
        f_d[c] = '0;
      end else if (neg) begin
        if (r.big || (r.quo > LIM)) begin
          f_d[c] = LIM[CW-1:0];
          sat_d  = 1'b1;
        end else begin
          f_d[c] = ~r.quo[CW-1:0] + 1'b1;
        end
      end else begin
        if (r.big || (r.quo >= LIM)) begin
          f_d[c] = LIM[CW-1:0] - 1'b1;
          sat_d  = 1'b1;
        end else begin
          f_d[c] = r.quo[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= OW'(f_d);
      tuser_q <= sat_d;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

endmodule
`default_nettype wire

[design/sbf_checker.sv]
// Port checker for the spring force block and its bind to the top level.
`default_nettype none
module sbf_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tready,
  input wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input wire logic                                m_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam logic [CW-1:0] FMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] FMAX = {1'b0, {(CW-1){1'b1}}};

  // A held output item keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // The input side only stalls when an output item is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input stalled without output backpressure");

  // A clamp flag needs at least one component at a limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[CW-1:0] == FMIN) || (m_axis_tdata[CW-1:0] == FMAX) ||
      (m_axis_tdata[2*CW-1:CW] == FMIN) || (m_axis_tdata[2*CW-1:CW] == FMAX) ||
      (m_axis_tdata[3*CW-1:2*CW] == FMIN) || (m_axis_tdata[3*CW-1:2*CW] == FMAX))
    else $error("saturated flag without a clamped component");

endmodule

bind spring_bungee_force sbf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire

[test/sbf_force_checker.sv]
// Checker that watches the spring force streams, predicts each force item and compares it.
`default_nettype none
module sbf_force_checker #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]   in_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]   out_data,
  input  wire logic                                 out_user,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [sbf_pkg::CFG_IDXW-1:0]         cfg_index,
  input  wire logic [sbf_pkg::CFG_DW-1:0]           cfg_data,
  output int                                        fail_count,
  output int                                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH;

  typedef struct {
    logic [CW-1:0] f[3];
    logic          sat;
  } force_t;

  force_t        expected_forces[$];
  logic [31:0]   stiffness;
  logic [30:0]   rest_len;
  logic          bungee;

  // Integer square root by bit trial; the sum of squares fits 66 bits.
  function automatic logic [63:0] isqrt(input logic [127:0] s);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= s) root = cand;
    end
    return root;
  endfunction

  function automatic force_t predict_force(input logic [6*CW-1:0] item);
    force_t            r;
    logic signed [CW:0] d[3];
    logic [127:0]      sumsq;
    logic [63:0]       len;
    logic signed [64:0] delta;
    logic [63:0]       adelta;
    logic [63:0]       ad;
    logic [191:0]      q;
    logic [63:0]       mag;
    logic [63:0]       limit;
    logic              neg;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(item[i*CW +: CW]) - $signed(item[(i+3)*CW +: CW]);
      ad = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
      sumsq += 128'(ad) * 128'(ad);
    end
    len = isqrt(sumsq);
    delta = $signed({1'b0, len}) - $signed({34'd0, rest_len});
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) r.f[i] = '0;
    if (len == 0 || delta == 0 || (bungee && delta <= 0)) return r;
    adelta = delta < 0 ? 64'(-delta) : 64'(delta);
    limit = 64'd1 << (CW - 1);
    for (int i = 0; i < 3; i++) begin
      if (d[i] != 0) begin
        ad = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
        q = ((192'(stiffness) * 192'(adelta) * 192'(ad)) / 192'(len)) >> FRAC_BITS;
        mag = q[63:0];
        neg = (delta < 0) == (d[i] < 0);
        if (neg) begin
          if (q[191:64] != 0 || mag > limit) begin
            r.sat = 1'b1;
            r.f[i] = limit[CW-1:0];
          end else begin
            r.f[i] = CW'(-mag);
          end
        end else if (q[191:64] != 0 || mag > limit - 1) begin
          r.sat = 1'b1;
          r.f[i] = CW'(limit - 1);
        end else begin
          r.f[i] = mag[CW-1:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    force_t e;
    int     errs;
    if (!rst_ni) begin
      stiffness     <= sbf_pkg::K_RESET;
      rest_len      <= sbf_pkg::REST_RESET;
      bungee        <= 1'b0;
      fail_count    <= 0;
      pending_count <= 0;
      expected_forces.delete();
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbf_pkg::CFG_SPRING_CONSTANT: stiffness <= cfg_data;
          sbf_pkg::CFG_REST_LENGTH:     rest_len  <= cfg_data[30:0];
          sbf_pkg::CFG_MODE:            bungee    <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_forces.insert(expected_forces.size(), predict_force(in_data[6*CW-1:0]));
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          $error("force item with no expectation waiting");
          errs++;
        end else begin
          e = expected_forces.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (out_data[i*CW +: CW] !== e.f[i]) begin
              $error("force_%s expected %h actual %h", i == 0 ? "x" : i == 1 ? "y" : "z",
                     e.f[i], out_data[i*CW +: CW]);
              errs++;
            end
          end
          if (out_user !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, out_user);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending_count <= expected_forces.size();
    end
  end
endmodule
`default_nettype wire

[test/tb_spring_bungee_force.sv]
// Testbench top that drives the spring force block and gives the verdict.
`default_nettype none
module tb_spring_bungee_force;
  timeunit 1ns;
  timeprecision 1ps;

  import sbf_pkg::*;

  localparam int CW      = 32;
  localparam int LATENCY = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic [6*CW-1:0]    s_axis_tdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [3*CW-1:0]    m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDXW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0]  cfg_data_i = '0;
  int                 fail_count;
  int                 pending_count;

  // Receiver behavior is steered by the stimulus process through these flags.
  bit                 calm = 1'b0;
  int                 hold_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  spring_bungee_force u_top (.*);

  sbf_force_checker u_checker (
    .clk_i, .rst_ni,
    .in_data(s_axis_tdata), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .cfg_valid(cfg_valid_i), .cfg_ready(cfg_ready_o),
    .cfg_index(cfg_index_i), .cfg_data(cfg_data_i),
    .fail_count, .pending_count
  );

  // Receiver: random stall bursts, plus one long hold-off so the pipeline fills up.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one item and waits for its acceptance; the sender may idle first.
  // Valid stays high afterwards so that items can follow back to back.
  task automatic send_pair(input logic [CW-1:0] px, py, pz, ex, ey, ez);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ez, ey, ex, pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord(input int span);
    case (span)
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 2 ** 20)) - (2 ** 19));
      default: return CW'($signed($urandom_range(0, 2 ** 18)) - (2 ** 17));
    endcase
  endfunction

  task automatic random_pairs(input int count);
    logic [CW-1:0] ex, ey, ez;
    int span;
    for (int n = 0; n < count; n++) begin
      span = $urandom_range(0, 3);
      ex = rand_coord(span); ey = rand_coord(span); ez = rand_coord(span);
      if ($urandom_range(0, 9) == 0)
        send_pair(ex, ey, ez, ex, ey, ez);
      else if ($urandom_range(0, 9) == 0)
        send_pair(ex + $urandom_range(0, 3), ey, ez, ex, ey, ez);
      else
        send_pair(ex + rand_coord(span), ey + rand_coord(span), ez + rand_coord(span),
                  ex, ey, ez);
    end
  endtask

  localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MINC = 32'h8000_0000;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at reset settings: zero separation, rest length, axes, extremes.
    send_pair('0, '0, '0, '0, '0, '0);
    send_pair(ONE, '0, '0, '0, '0, '0);
    send_pair('0, ONE, '0, '0, '0, '0);
    send_pair('0, '0, 32'h0002_0000, '0, '0, '0);
    send_pair(32'h0000_8000, '0, '0, '0, '0, '0);
    send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_pair(MAXC, '0, MINC, MINC, MAXC, '0);
    send_pair(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, '0, '0, '0);
    send_pair(32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0);
    drain();

    // Stiff spring to force saturation, then bungee mode with slack and stretch.
    write_reg(CFG_SPRING_CONSTANT, 32'hFFFF_FFFF);
    write_reg(CFG_REST_LENGTH, 32'h0);
    send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_pair(32'h0100_0000, 32'hFF00_0000, '0, '0, '0, '0);
    send_pair(32'h0000_0001, '0, '0, '0, '0, '0);
    drain();
    write_reg(CFG_MODE, 32'hFFFF_FFFF);
    write_reg(CFG_REST_LENGTH, 32'hFFFF_FFFF);
    write_reg(CFG_SPRING_CONSTANT, ONE);
    send_pair(MAXC, '0, '0, MINC, '0, '0);
    send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_pair(ONE, '0, '0, '0, '0, '0);
    drain();
    write_reg(CFG_REST_LENGTH, 32'h0002_0000);
    send_pair(32'h0001_0000, '0, '0, '0, '0, '0);
    send_pair(32'h0003_0000, '0, '0, '0, '0, '0);
    send_pair(32'hFFFD_0000, 32'h0002_0000, '0, '0, '0, '0);
    send_pair(32'h0002_0000, '0, '0, '0, '0, '0);
    drain();

    // Random phases over several settings; the long hold-off lands in the first.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_SPRING_CONSTANT, phase == 0 ? 32'h0 : $urandom);
      write_reg(CFG_REST_LENGTH, phase == 1 ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0010_0000));
      write_reg(CFG_MODE, $urandom_range(0, 1));
      if (phase == 0) hold_cycles = 200;
      if (phase == 5) calm = 1'b1;
      random_pairs(80);
      drain();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
design/sbf_pkg.sv
design/spring_bungee_force.sv
design/sbf_checker.sv
test/sbf_force_checker.sv
test/tb_spring_bungee_force.sv
